// File: hw/rtl/lcg_pkg.sv
// Shared types, constants and the sine table builder for the linear chirp generator.
`default_nettype none

package lcg_pkg;

	localparam int TAB_BITS = 10;
	localparam int OUT_BITS = 16;
	localparam int TAB_SIZE = 1 << TAB_BITS;
	localparam int QUARTER = TAB_SIZE / 4;
	localparam int PHASE_BITS = 32;
	localparam int COUNT_BITS = 16;
	localparam int AMP_BITS = 15;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_IDX_BITS = 2;

	localparam longint Q30_ONE = 64'sd1 << 30;
	localparam longint FULL_SCALE = (64'sd1 <<< (OUT_BITS - 1)) - 64'sd1;

	typedef logic signed [OUT_BITS-1:0] sample_t;
	typedef logic [TAB_BITS-1:0] tab_addr_t;
	typedef sample_t sine_tab_t [TAB_SIZE];

	localparam sample_t SAMPLE_MIN = {1'b1, {(OUT_BITS - 1){1'b0}}};

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_START_STEP   = 2'd0,
		REG_CHIRP_RATE   = 2'd1,
		REG_AMPLITUDE    = 2'd2,
		REG_CHIRP_LENGTH = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [PHASE_BITS-1:0]        start_step;
		logic signed [PHASE_BITS-1:0] chirp_rate;
		logic [AMP_BITS-1:0]          amplitude;
		logic [COUNT_BITS-1:0]        chirp_length;
	} cfg_t;

	localparam logic [PHASE_BITS-1:0] START_STEP_RST = 32'd10792686;
	localparam logic signed [PHASE_BITS-1:0] CHIRP_RATE_RST = 32'sd110536;
	localparam logic [AMP_BITS-1:0] AMPLITUDE_RST = 15'd22938;
	localparam logic [COUNT_BITS-1:0] CHIRP_LENGTH_RST = 16'd680;

	// Rounds a Q30 product back to Q30, half away from zero.
	function automatic longint rnd_q30(longint p);
		longint half;
		half = 64'sd1 <<< 29;
		if (p >= 0) begin
			return (p + half) >>> 30;
		end
		return -(((-p) + half) >>> 30);
	endfunction

	function automatic logic [63:0] isqrt_u64(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] rem;
		logic [63:0] bit_v;
		r = '0;
		rem = v;
		bit_v = 64'd1 << 62;
		for (int n = 0; n < 32; n++) begin
			if (rem >= r + bit_v) begin
				rem = rem - (r + bit_v);
				r = (r >> 1) + bit_v;
			end else begin
				r = r >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] udiv_u64(logic [63:0] num, logic [63:0] den);
		logic [63:0] q;
		logic [63:0] rem;
		q = '0;
		rem = '0;
		for (int n = 63; n >= 0; n--) begin
			rem = {rem[62:0], num[n]};
			if (rem >= den) begin
				rem = rem - den;
				q[n] = 1'b1;
			end
		end
		return q;
	endfunction

	// Entry k is the product of halved-angle rotations for the set bits of k, scaled to
	// full scale.
	function automatic sine_tab_t build_sine_tab();
		longint hc [TAB_BITS+1];
		longint hs [TAB_BITS+1];
		longint c;
		longint s;
		longint nc;
		longint ns;
		longint rc;
		longint rs;
		longint v;
		logic [63:0] uv;
		sine_tab_t tab;
		hc[0] = Q30_ONE;
		hs[0] = 0;
		hc[1] = -Q30_ONE;
		hs[1] = 0;
		hc[2] = 0;
		hs[2] = Q30_ONE;
		for (int j = 3; j <= TAB_BITS; j++) begin
			uv = Q30_ONE + hc[j-1];
			uv = uv << 29;
			hc[j] = signed'(isqrt_u64(uv));
			uv = hs[j-1];
			uv = uv << 29;
			hs[j] = signed'(udiv_u64(uv, hc[j]));
		end
		for (int k = 0; k < TAB_SIZE; k++) begin
			c = Q30_ONE;
			s = 0;
			for (int m = 0; m < TAB_BITS; m++) begin
				if (((k >> m) & 1) != 0) begin
					rc = hc[TAB_BITS-m];
					rs = hs[TAB_BITS-m];
					nc = rnd_q30(c * rc - s * rs);
					ns = rnd_q30(c * rs + s * rc);
					c = nc;
					s = ns;
				end
			end
			v = rnd_q30(s * FULL_SCALE);
			if (v > FULL_SCALE) begin
				v = FULL_SCALE;
			end
			if (v < -FULL_SCALE) begin
				v = -FULL_SCALE;
			end
			tab[k] = v[OUT_BITS-1:0];
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

// File: hw/rtl/lcg_in_if.sv
// Input channel: one beat per sample tick, carrying the restart flag.
`default_nettype none

interface lcg_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source(output valid, output restart, input ready);
	modport sink(input valid, input restart, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lcg_out_if.sv
// Output channel: one complex chirp sample and its last flag per beat.
`default_nettype none

interface lcg_out_if;
	logic             valid;
	logic             ready;
	lcg_pkg::sample_t sample_i;
	lcg_pkg::sample_t sample_q;
	logic             last_sample;

	modport source(output valid, output sample_i, output sample_q, output last_sample,
		input ready);
	modport sink(input valid, input sample_i, input sample_q, input last_sample,
		output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lcg_regs.sv
// Configuration register file with its write decoder.
`default_nettype none

module lcg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               wr_en,
	input  wire logic [lcg_pkg::CFG_IDX_BITS-1:0]   wr_index,
	input  wire logic [lcg_pkg::CFG_DATA_BITS-1:0]  wr_data,
	output lcg_pkg::cfg_t                           cfg
);
	import lcg_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_step <= START_STEP_RST;
			cfg_q.chirp_rate <= CHIRP_RATE_RST;
			cfg_q.amplitude <= AMPLITUDE_RST;
			cfg_q.chirp_length <= CHIRP_LENGTH_RST;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_START_STEP: cfg_q.start_step <= wr_data[PHASE_BITS-1:0];
				REG_CHIRP_RATE: cfg_q.chirp_rate <= signed'(wr_data[PHASE_BITS-1:0]);
				REG_AMPLITUDE: cfg_q.amplitude <= wr_data[AMP_BITS-1:0];
				REG_CHIRP_LENGTH: cfg_q.chirp_length <= wr_data[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

`default_nettype wire

// File: hw/rtl/lcg_phase.sv
// Phase accumulator, growing step and sample counter, with table addresses and last flag.
`default_nettype none

module lcg_phase (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          restart,
	input  wire lcg_pkg::cfg_t cfg,
	output lcg_pkg::tab_addr_t sin_addr,
	output lcg_pkg::tab_addr_t cos_addr,
	output logic               last
);
	import lcg_pkg::*;

	logic [PHASE_BITS-1:0] phase_acc_q;
	logic [PHASE_BITS-1:0] phase_step_q;
	logic [COUNT_BITS-1:0] sample_count_q;

	logic [PHASE_BITS-1:0] acc_eff;
	logic [PHASE_BITS-1:0] step_eff;
	logic [COUNT_BITS-1:0] count_eff;
	logic [COUNT_BITS:0]   count_next;

	always_comb begin
		acc_eff = restart ? '0 : phase_acc_q;
		step_eff = restart ? cfg.start_step : phase_step_q;
		count_eff = restart ? '0 : sample_count_q;
		count_next = {1'b0, count_eff} + {{COUNT_BITS{1'b0}}, 1'b1};
		// A zero length compares as always reached, so every sample is last.
		last = (count_next >= {1'b0, cfg.chirp_length});
		sin_addr = acc_eff[PHASE_BITS-1 -: TAB_BITS];
		cos_addr = sin_addr + tab_addr_t'(QUARTER);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
			phase_step_q <= START_STEP_RST;
			sample_count_q <= '0;
		end else if (adv) begin
			if (last) begin
				phase_acc_q <= '0;
				phase_step_q <= cfg.start_step;
				sample_count_q <= '0;
			end else begin
				phase_acc_q <= acc_eff + step_eff;
				phase_step_q <= step_eff + unsigned'(cfg.chirp_rate);
				sample_count_q <= count_next[COUNT_BITS-1:0];
			end
		end
	end
endmodule

`default_nettype wire

// File: hw/rtl/lcg_sine_rom.sv
// Dual-port sine table ROM with registered read data.
`default_nettype none

module lcg_sine_rom (
	input  wire logic               clk,
	input  wire logic               rd_en,
	input  wire lcg_pkg::tab_addr_t addr_a,
	input  wire lcg_pkg::tab_addr_t addr_b,
	output lcg_pkg::sample_t        data_a,
	output lcg_pkg::sample_t        data_b
);
	import lcg_pkg::*;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_a <= SINE_TAB[addr_a];
			data_b <= SINE_TAB[addr_b];
		end
	end
endmodule

`default_nettype wire

// File: hw/rtl/lcg_scale.sv
// Amplitude scaling of the cosine and sine entries with rounding half away from zero.
`default_nettype none

module lcg_scale (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [lcg_pkg::AMP_BITS-1:0] amplitude,
	input  wire lcg_pkg::sample_t             cos_s1,
	input  wire lcg_pkg::sample_t             sin_s1,
	output lcg_pkg::sample_t                  sample_i_s2,
	output lcg_pkg::sample_t                  sample_q_s2
);
	import lcg_pkg::*;

	localparam int MAG_BITS = OUT_BITS - 1;
	localparam int PROD_BITS = AMP_BITS + MAG_BITS;

	// Table entries never reach the most negative code, so the magnitude fits MAG_BITS.
	function automatic sample_t scale(logic [AMP_BITS-1:0] amp, sample_t e);
		logic [MAG_BITS-1:0]  mag;
		logic [PROD_BITS-1:0] prod;
		logic [PROD_BITS-1:0] sum;
		sample_t              r;
		mag = e[OUT_BITS-1] ? MAG_BITS'(-e) : e[MAG_BITS-1:0];
		prod = PROD_BITS'(amp) * PROD_BITS'(mag);
		sum = prod + (PROD_BITS'(1) << (AMP_BITS - 1));
		r = {1'b0, sum[PROD_BITS-1 -: MAG_BITS]};
		return e[OUT_BITS-1] ? -r : r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			sample_i_s2 <= scale(amplitude, cos_s1);
			sample_q_s2 <= scale(amplitude, sin_s1);
		end
	end
endmodule

`default_nettype wire

// File: hw/rtl/linear_chirp_generator.sv
// Top level of the linear-FM chirp generator: configuration, phase, table and scaling.
//
//   Channel   Direction  Beat carries
//   in_ch     sink       restart
//   out_ch    source     sample_i, sample_q, last_sample
//   wr_*      write      register index and data, no read-back
//
// One sample per clock is sustained while out_ch.ready is high; a beat's result passes
// through the registered sine table read and then the registered amplitude multiply.
// Each stage holds its contents while the stage after it is full and stalled, so a
// stalled output still lets an item enter an empty stage. Reset clears the valid bits,
// the phase state and the registers to their defaults.
`default_nettype none

module linear_chirp_generator (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	lcg_in_if.sink                                  in_ch,
	lcg_out_if.source                               out_ch,
	input  wire logic                               wr_en,
	input  wire logic [lcg_pkg::CFG_IDX_BITS-1:0]   wr_index,
	input  wire logic [lcg_pkg::CFG_DATA_BITS-1:0]  wr_data
);
	import lcg_pkg::*;

	cfg_t      cfg;
	tab_addr_t sin_addr;
	tab_addr_t cos_addr;
	logic      last;
	sample_t   sin_s1;
	sample_t   cos_s1;
	logic      valid_s1;
	logic      last_s1;
	logic      valid_s2;
	logic      last_s2;
	logic      en_s1;
	logic      en_s2;
	logic      accept;

	assign en_s2 = !valid_s2 || out_ch.ready;
	assign en_s1 = !valid_s1 || en_s2;
	assign in_ch.ready = en_s1;
	assign accept = in_ch.valid && en_s1;

	lcg_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	lcg_phase u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (accept),
		.restart  (in_ch.restart),
		.cfg      (cfg),
		.sin_addr (sin_addr),
		.cos_addr (cos_addr),
		.last     (last)
	);

	lcg_sine_rom u_rom (
		.clk    (clk),
		.rd_en  (en_s1),
		.addr_a (sin_addr),
		.addr_b (cos_addr),
		.data_a (sin_s1),
		.data_b (cos_s1)
	);

	lcg_scale u_scale (
		.clk         (clk),
		.en          (en_s2),
		.amplitude   (cfg.amplitude),
		.cos_s1      (cos_s1),
		.sin_s1      (sin_s1),
		.sample_i_s2 (out_ch.sample_i),
		.sample_q_s2 (out_ch.sample_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_ch.valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			last_s1 <= last;
		end
		if (en_s2) begin
			last_s2 <= last_s1;
		end
	end

	assign out_ch.valid = valid_s2;
	assign out_ch.last_sample = last_s2;
endmodule

`default_nettype wire

// File: hw/rtl/lcg_checker.sv
// Port-level checks for the chirp generator and the bind that attaches them.
`default_nettype none

module lcg_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire lcg_pkg::sample_t sample_i,
	input wire lcg_pkg::sample_t sample_q
);
	import lcg_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the output stage is empty");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready |=> out_valid)
		else $error("accepted beat did not reach the output in two cycles");

	a_no_min_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sample_i != SAMPLE_MIN) && (sample_q != SAMPLE_MIN))
		else $error("sample exceeds symmetric full scale");
endmodule

bind linear_chirp_generator lcg_checker u_lcg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.sample_i  (out_ch.sample_i),
	.sample_q  (out_ch.sample_q)
);

`default_nettype wire
